// ===== rtl/fdt_pkg.sv =====
package fdt_pkg;

  // Table geometry.
  localparam int ENTRIES           = 32;
  localparam int SECTORS_PER_BLOCK = 2;
  localparam int NAME_BYTES        = 12;
  localparam int IDX_W             = $clog2(ENTRIES);
  localparam int EXT_W             = 9;
  localparam int FIDX_W            = 5;

  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);
  localparam logic [EXT_W-1:0] ENTRIES_EXT = EXT_W'(ENTRIES);
  localparam logic [15:0]      SPB_STEP    = 16'(SECTORS_PER_BLOCK);
  localparam logic [15:0]      FIRST_SEC   = 16'd1;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_FORMAT  = 3'd0,
    REQ_UNMOUNT = 3'd1,
    REQ_CREATE  = 3'd2,
    REQ_DELETE  = 3'd3,
    REQ_LOOKUP  = 3'd4,
    REQ_NEXT    = 3'd5
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FAIL   = 2'd1,
    ST_NOFILE = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FORMAT,
    S_SCAN,
    S_RESP
  } state_t;

  // One request as it arrives.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] name_low;
    logic [31:0] name_high;
    logic [5:0]  start_index;
  } in_req_t;

  // One result.
  typedef struct packed {
    status_t     status;
    logic [15:0] start_sector;
    logic [63:0] found_name_low;
    logic [31:0] found_name_high;
    logic [4:0]  found_index;
  } resp_t;

  // Table memory access from the sequencer.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             name_we;
    logic             sec_we;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0]      wr_name_lo;
    logic [31:0]      wr_name_hi;
    logic [15:0]      wr_sec;
  } mem_req_t;

  // Registered read data of the table memory.
  typedef struct packed {
    logic [63:0] name_lo;
    logic [31:0] name_hi;
    logic [15:0] sec;
  } mem_rsp_t;

  // Comparator verdict on the entry just read.
  typedef struct packed {
    logic match;
    logic used;
  } cmp_t;

  // Entry index reduced to the five bits of the result field.
  function automatic logic [FIDX_W-1:0] to_found_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+FIDX_W-1:0] ext;
    ext = {{FIDX_W{1'b0}}, idx};
    return ext[FIDX_W-1:0];
  endfunction

endpackage

// ===== rtl/fdt_ifs.sv =====
// Request channel.
interface fdt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] name_low;
  logic [31:0] name_high;
  logic [5:0]  start_index;

  modport source (output valid, req_type, name_low, name_high, start_index, input ready);
  modport sink   (input valid, req_type, name_low, name_high, start_index, output ready);
endinterface

// Result channel.
interface fdt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] start_sector;
  logic [63:0] found_name_low;
  logic [31:0] found_name_high;
  logic [4:0]  found_index;

  modport source (output valid, status, start_sector, found_name_low, found_name_high,
                  found_index, input ready);
  modport sink   (input valid, status, start_sector, found_name_low, found_name_high,
                  found_index, output ready);
endinterface

// ===== rtl/file_directory_table_core.sv =====
// Flat file directory of 32 entries, each a 12-byte name and a first sector.
// Requests arrive on in_chan (valid/ready); an item transfers when both are high.
// Each request gives exactly one result on out_chan, in request order.
// Unmount, unknown codes and requests refused up front answer without a scan.
// Format sweeps the table one entry per cycle. Create, delete, lookup and next
// name scan the entries through the single memory read port and the one name
// comparator, one entry per cycle with registered read data; the scan may stop
// early at a hit. One request is in work at a time.
// Reset clears the mounted flag and the sequencer; the table itself is left
// undefined until the first format.
// The result sits in an output register, so a new request is taken while an
// earlier result waits; if the receiver stalls, the next finished result waits
// inside the sequencer and no further request is taken until it moves out.
module file_directory_table_core (
  input  logic           clk,
  input  logic           rst_n,
  fdt_in_if.sink         in_chan,
  fdt_out_if.source      out_chan
);

  fdt_pkg::in_req_t   in_req;
  fdt_pkg::cmp_t      cmp;
  fdt_pkg::mem_req_t  mreq;
  fdt_pkg::mem_rsp_t  mrsp;
  fdt_pkg::resp_t     resp;
  fdt_pkg::resp_t     out_res_r;
  logic [63:0]        query_lo;
  logic [31:0]        query_hi;
  logic               resp_valid;
  logic               resp_ready;
  logic               out_valid_r;

  assign in_req.req_type    = in_chan.req_type;
  assign in_req.name_low    = in_chan.name_low;
  assign in_req.name_high   = in_chan.name_high;
  assign in_req.start_index = in_chan.start_index;

  fdt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_req     (in_req),
    .query_lo   (query_lo),
    .query_hi   (query_hi),
    .cmp        (cmp),
    .mreq       (mreq),
    .mrsp       (mrsp),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
  );

  fdt_table_mem u_mem (
    .clk  (clk),
    .mreq (mreq),
    .mrsp (mrsp)
  );

  fdt_name_match u_match (
    .query_lo (query_lo),
    .query_hi (query_hi),
    .entry_lo (mrsp.name_lo),
    .entry_hi (mrsp.name_hi),
    .cmp      (cmp)
  );

  // Output register: loads when empty or when its result transfers.
  assign resp_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_res_r <= resp;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_res_r.status;
  assign out_chan.start_sector    = out_res_r.start_sector;
  assign out_chan.found_name_low  = out_res_r.found_name_low;
  assign out_chan.found_name_high = out_res_r.found_name_high;
  assign out_chan.found_index     = out_res_r.found_index;

endmodule

// ===== rtl/fdt_name_match.sv =====
module fdt_name_match (
  input  logic [63:0]  query_lo,
  input  logic [31:0]  query_hi,
  input  logic [63:0]  entry_lo,
  input  logic [31:0]  entry_hi,
  output fdt_pkg::cmp_t cmp
);

  logic [8*fdt_pkg::NAME_BYTES-1:0] qa;
  logic [8*fdt_pkg::NAME_BYTES-1:0] ea;

  assign qa = {query_hi, query_lo};
  assign ea = {entry_hi, entry_lo};

  // Names agree up to and including the first NUL, or on every byte.
  always_comb begin
    logic ended;
    logic ok;
    ended = 1'b0;
    ok    = 1'b1;
    for (int k = 0; k < fdt_pkg::NAME_BYTES; k++) begin
      if (!ended) begin
        if (qa[8*k +: 8] != ea[8*k +: 8]) begin
          ok = 1'b0;
        end
        if (qa[8*k +: 8] == 8'd0) begin
          ended = 1'b1;
        end
      end
    end
    cmp.match = ok;
    cmp.used  = (entry_lo[7:0] != 8'd0);
  end

endmodule

// ===== rtl/fdt_table_mem.sv =====
module fdt_table_mem (
  input  logic               clk,
  input  fdt_pkg::mem_req_t  mreq,
  output fdt_pkg::mem_rsp_t  mrsp
);

  logic [95:0] name_mem [fdt_pkg::ENTRIES];
  logic [15:0] sec_mem  [fdt_pkg::ENTRIES];
  logic [95:0] name_rd_r;
  logic [15:0] sec_rd_r;

  // Write port: names and sectors are written independently.
  always_ff @(posedge clk) begin
    if (mreq.name_we) begin
      name_mem[mreq.wr_addr] <= {mreq.wr_name_hi, mreq.wr_name_lo};
    end
    if (mreq.sec_we) begin
      sec_mem[mreq.wr_addr] <= mreq.wr_sec;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (mreq.rd_en) begin
      name_rd_r <= name_mem[mreq.rd_addr];
      sec_rd_r  <= sec_mem[mreq.rd_addr];
    end
  end

  assign mrsp.name_lo = name_rd_r[63:0];
  assign mrsp.name_hi = name_rd_r[95:64];
  assign mrsp.sec     = sec_rd_r;

endmodule

// ===== rtl/fdt_ctrl.sv =====
module fdt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fdt_pkg::in_req_t   in_req,
  output logic [63:0]        query_lo,
  output logic [31:0]        query_hi,
  input  fdt_pkg::cmp_t      cmp,
  output fdt_pkg::mem_req_t  mreq,
  input  fdt_pkg::mem_rsp_t  mrsp,
  output logic               resp_valid,
  input  logic               resp_ready,
  output fdt_pkg::resp_t     resp
);

  fdt_pkg::state_t            state_r, state_nxt;
  fdt_pkg::req_t              req_r, req_nxt;
  logic [63:0]                q_lo_r, q_lo_nxt;
  logic [31:0]                q_hi_r, q_hi_nxt;
  logic [fdt_pkg::IDX_W-1:0]  addr_r, addr_nxt;
  logic                       issue_r, issue_nxt;
  logic                       pend_r, pend_nxt;
  logic [fdt_pkg::IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic                       free_found_r, free_found_nxt;
  logic [fdt_pkg::IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [15:0]                sec_r, sec_nxt;
  logic                       mounted_r, mounted_nxt;
  fdt_pkg::resp_t             res_r, res_nxt;

  logic                       in_fire;
  logic [fdt_pkg::EXT_W-1:0]  start_ext;
  logic                       last;

  assign in_ready  = (state_r == fdt_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign start_ext = {{(fdt_pkg::EXT_W - 6){1'b0}}, in_req.start_index};
  assign last      = (pend_idx_r == fdt_pkg::LAST_IDX);
  assign query_lo  = q_lo_r;
  assign query_hi  = q_hi_r;
  assign resp      = res_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fdt_pkg::S_IDLE;
      issue_r      <= 1'b0;
      pend_r       <= 1'b0;
      free_found_r <= 1'b0;
      mounted_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      pend_r       <= pend_nxt;
      free_found_r <= free_found_nxt;
      mounted_r    <= mounted_nxt;
    end
  end

  // Request and working registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    q_lo_r     <= q_lo_nxt;
    q_hi_r     <= q_hi_nxt;
    addr_r     <= addr_nxt;
    pend_idx_r <= pend_idx_nxt;
    free_idx_r <= free_idx_nxt;
    sec_r      <= sec_nxt;
    res_r      <= res_nxt;
  end

  // Sequencer: request decode, format sweep, one-entry-per-cycle scan and response hand-off.
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    q_lo_nxt       = q_lo_r;
    q_hi_nxt       = q_hi_r;
    addr_nxt       = addr_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    sec_nxt        = sec_r;
    mounted_nxt    = mounted_r;
    res_nxt        = res_r;
    resp_valid     = 1'b0;
    mreq           = '0;

    case (state_r)
      fdt_pkg::S_IDLE: begin
        if (in_fire) begin
          req_nxt        = fdt_pkg::req_t'(in_req.req_type);
          q_lo_nxt       = in_req.name_low;
          q_hi_nxt       = in_req.name_high;
          res_nxt        = '0;
          res_nxt.status = fdt_pkg::ST_FAIL;
          addr_nxt       = '0;
          issue_nxt      = 1'b1;
          pend_nxt       = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = fdt_pkg::S_RESP;
          case (in_req.req_type)
            fdt_pkg::REQ_FORMAT: begin
              sec_nxt   = fdt_pkg::FIRST_SEC;
              state_nxt = fdt_pkg::S_FORMAT;
            end
            fdt_pkg::REQ_UNMOUNT: begin
              mounted_nxt    = 1'b0;
              res_nxt.status = fdt_pkg::ST_OK;
            end
            fdt_pkg::REQ_CREATE: begin
              if (mounted_r && in_req.name_low[7:0] != 8'd0) begin
                state_nxt = fdt_pkg::S_SCAN;
              end
            end
            fdt_pkg::REQ_DELETE: begin
              if (mounted_r) begin
                state_nxt = fdt_pkg::S_SCAN;
              end
            end
            fdt_pkg::REQ_LOOKUP: begin
              if (mounted_r) begin
                if (in_req.name_low[7:0] != 8'd0) begin
                  state_nxt = fdt_pkg::S_SCAN;
                end else begin
                  res_nxt.status = fdt_pkg::ST_NOFILE;
                end
              end
            end
            fdt_pkg::REQ_NEXT: begin
              if (mounted_r && start_ext < fdt_pkg::ENTRIES_EXT) begin
                addr_nxt  = start_ext[fdt_pkg::IDX_W-1:0];
                state_nxt = fdt_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      fdt_pkg::S_FORMAT: begin
        // One entry per cycle: empty name and its initial sector.
        mreq.name_we = 1'b1;
        mreq.sec_we  = 1'b1;
        mreq.wr_addr = addr_r;
        mreq.wr_sec  = sec_r;
        if (addr_r == fdt_pkg::LAST_IDX) begin
          mounted_nxt    = 1'b1;
          res_nxt.status = fdt_pkg::ST_OK;
          state_nxt      = fdt_pkg::S_RESP;
        end else begin
          addr_nxt = addr_r + 1'b1;
          sec_nxt  = sec_r + fdt_pkg::SPB_STEP;
        end
      end

      fdt_pkg::S_SCAN: begin
        // Read side: one entry issued per cycle until the last one.
        if (issue_r) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = addr_r;
          if (addr_r == fdt_pkg::LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        pend_nxt     = issue_r;
        pend_idx_nxt = addr_r;

        // Check side: the entry whose read was issued in the cycle before.
        if (pend_r) begin
          case (req_r)
            fdt_pkg::REQ_CREATE: begin
              if (cmp.match) begin
                state_nxt = fdt_pkg::S_RESP;
              end else if (last) begin
                if (free_found_r || !cmp.used) begin
                  mreq.name_we    = 1'b1;
                  mreq.wr_addr    = free_found_r ? free_idx_r : pend_idx_r;
                  mreq.wr_name_lo = q_lo_r;
                  mreq.wr_name_hi = q_hi_r;
                  res_nxt.status  = fdt_pkg::ST_OK;
                end
                state_nxt = fdt_pkg::S_RESP;
              end else if (!cmp.used && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = pend_idx_r;
              end
            end
            fdt_pkg::REQ_DELETE: begin
              if (cmp.match) begin
                mreq.name_we    = 1'b1;
                mreq.wr_addr    = pend_idx_r;
                mreq.wr_name_lo = {mrsp.name_lo[63:8], 8'd0};
                mreq.wr_name_hi = mrsp.name_hi;
                res_nxt.status  = fdt_pkg::ST_OK;
                state_nxt       = fdt_pkg::S_RESP;
              end else if (last) begin
                state_nxt = fdt_pkg::S_RESP;
              end
            end
            fdt_pkg::REQ_LOOKUP: begin
              if (cmp.match) begin
                res_nxt.status       = fdt_pkg::ST_OK;
                res_nxt.start_sector = mrsp.sec;
                res_nxt.found_index  = fdt_pkg::to_found_idx(pend_idx_r);
                state_nxt            = fdt_pkg::S_RESP;
              end else if (last) begin
                res_nxt.status = fdt_pkg::ST_NOFILE;
                state_nxt      = fdt_pkg::S_RESP;
              end
            end
            fdt_pkg::REQ_NEXT: begin
              if (cmp.used) begin
                res_nxt.status          = fdt_pkg::ST_OK;
                res_nxt.found_name_low  = mrsp.name_lo;
                res_nxt.found_name_high = mrsp.name_hi;
                res_nxt.found_index     = fdt_pkg::to_found_idx(pend_idx_r);
                state_nxt               = fdt_pkg::S_RESP;
              end else if (last) begin
                state_nxt = fdt_pkg::S_RESP;
              end
            end
            default: begin
              state_nxt = fdt_pkg::S_RESP;
            end
          endcase
          if (state_nxt == fdt_pkg::S_RESP) begin
            issue_nxt = 1'b0;
            pend_nxt  = 1'b0;
          end
        end
      end

      fdt_pkg::S_RESP: begin
        resp_valid = 1'b1;
        if (resp_ready) begin
          state_nxt = fdt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fdt_pkg::S_IDLE;
      end
    endcase
  end

  // A table request on an unmounted table answers without a scan.
  a_unmounted_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !mounted_r && (in_req.req_type == fdt_pkg::REQ_CREATE ||
      in_req.req_type == fdt_pkg::REQ_DELETE || in_req.req_type == fdt_pkg::REQ_LOOKUP ||
      in_req.req_type == fdt_pkg::REQ_NEXT)) |=> (state_r == fdt_pkg::S_RESP))
    else $error("unmounted table request did not answer at once");

  // The end of the format sweep leaves the table mounted.
  a_format_mounts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fdt_pkg::S_FORMAT && addr_r == fdt_pkg::LAST_IDX) |=> mounted_r)
    else $error("format sweep finished without mounting");

  // During a scan, names are written only on a checked entry.
  a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fdt_pkg::S_SCAN && mreq.name_we) |-> (pend_r && state_nxt == fdt_pkg::S_RESP))
    else $error("name write during scan without a verdict");

  // A pending response holds its value until it is taken.
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (resp_valid && !resp_ready) |=> (resp_valid && $stable(res_r)))
    else $error("response changed before it was taken");

endmodule

// ===== sim/fdt_checker.sv =====
// Watches both channels of the directory core, keeps its own copy of the
// directory, predicts the answer to every request that transfers and checks
// each result transfer against the oldest outstanding answer.
module fdt_checker
  import fdt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fdt_in_if    in_mon,
  fdt_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);

  // Shadow directory: names, first sectors and the mounted flag.
  logic [63:0] dir_name_lo [ENTRIES];
  logic [31:0] dir_name_hi [ENTRIES];
  logic [15:0] dir_sector  [ENTRIES];
  logic        dir_mounted;

  // Answers predicted for requests whose result has not arrived yet.
  resp_t pending_answers [$];
  int    answers_waiting;
  int    failures;

  assign fail_count    = failures;
  assign pending_count = answers_waiting;

  initial begin
    dir_mounted     = 1'b0;
    answers_waiting = 0;
    failures        = 0;
  end

  // Print one line per failure and count it.
  task automatic report_failure(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    failures++;
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      report_failure($sformatf("%s differs: expected %0h, got %0h", field, want, got));
    end
  endtask

  // Names agree up to and including the first NUL byte, or on all 12 bytes.
  function automatic bit names_equal(input logic [63:0] a_lo, input logic [31:0] a_hi,
                                     input logic [63:0] b_lo, input logic [31:0] b_hi);
    logic [95:0] a;
    logic [95:0] b;
    a = {a_hi, a_lo};
    b = {b_hi, b_lo};
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (a[8*k +: 8] != b[8*k +: 8]) return 1'b0;
      if (a[8*k +: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  // First entry whose name matches, or ENTRIES when there is none.
  function automatic int find_named(input logic [63:0] lo, input logic [31:0] hi);
    for (int k = 0; k < ENTRIES; k++) begin
      if (names_equal(lo, hi, dir_name_lo[k], dir_name_hi[k])) return k;
    end
    return ENTRIES;
  endfunction

  // Apply one request to the shadow directory and work out its answer.
  task automatic apply_request(input logic [2:0] rq, input logic [63:0] lo,
                               input logic [31:0] hi, input logic [5:0] start,
                               output resp_t res);
    int slot;
    res        = '0;
    res.status = ST_FAIL;
    case (rq)
      REQ_FORMAT: begin
        for (int k = 0; k < ENTRIES; k++) begin
          dir_name_lo[k] = '0;
          dir_name_hi[k] = '0;
          dir_sector[k]  = 16'(1 + k * SECTORS_PER_BLOCK);
        end
        dir_mounted = 1'b1;
        res.status  = ST_OK;
      end
      REQ_UNMOUNT: begin
        dir_mounted = 1'b0;
        res.status  = ST_OK;
      end
      REQ_CREATE: begin
        if (dir_mounted && lo[7:0] != 8'h00 && find_named(lo, hi) == ENTRIES) begin
          slot = 0;
          while (slot < ENTRIES && dir_name_lo[slot][7:0] != 8'h00) slot++;
          if (slot < ENTRIES) begin
            dir_name_lo[slot] = lo;
            dir_name_hi[slot] = hi;
            res.status        = ST_OK;
          end
        end
      end
      REQ_DELETE: begin
        // An empty name hits the first unused entry, so nothing visible changes.
        if (dir_mounted) begin
          slot = find_named(lo, hi);
          if (slot < ENTRIES) begin
            dir_name_lo[slot][7:0] = 8'h00;
            res.status             = ST_OK;
          end
        end
      end
      REQ_LOOKUP: begin
        if (dir_mounted) begin
          res.status = ST_NOFILE;
          if (lo[7:0] != 8'h00) begin
            slot = find_named(lo, hi);
            if (slot < ENTRIES) begin
              res.status       = ST_OK;
              res.start_sector = dir_sector[slot];
              res.found_index  = FIDX_W'(slot);
            end
          end
        end
      end
      REQ_NEXT: begin
        if (dir_mounted && int'(start) < ENTRIES) begin
          slot = int'(start);
          while (slot < ENTRIES && dir_name_lo[slot][7:0] == 8'h00) slot++;
          if (slot < ENTRIES) begin
            res.status          = ST_OK;
            res.found_name_low  = dir_name_lo[slot];
            res.found_name_high = dir_name_hi[slot];
            res.found_index     = FIDX_W'(slot);
          end
        end
      end
      default: begin
        // Reserved request codes fail and leave the directory alone.
      end
    endcase
  endtask

  // Predict on every request transfer and check every result transfer.
  always @(posedge clk) begin : monitor
    resp_t want;
    if (!rst_n) begin
      dir_mounted = 1'b0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        apply_request(in_mon.req_type, in_mon.name_low, in_mon.name_high,
                      in_mon.start_index, want);
        pending_answers.push_back(want);
        answers_waiting++;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_answers.size() == 0) begin
          report_failure("result transfer with no request outstanding");
        end else begin
          want = pending_answers.pop_front();
          answers_waiting--;
          compare_field("status", 64'(want.status), 64'(out_mon.status));
          compare_field("start_sector", 64'(want.start_sector), 64'(out_mon.start_sector));
          compare_field("found_name_low", want.found_name_low, out_mon.found_name_low);
          compare_field("found_name_high", 64'(want.found_name_high),
                        64'(out_mon.found_name_high));
          compare_field("found_index", 64'(want.found_index), 64'(out_mon.found_index));
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the directory core test: clock, reset, request stimulus, result
// back-pressure, a watchdog and the verdict.
module testbench;
  import fdt_pkg::*;

  localparam logic [2:0] REQ_RSVD_A = 3'd6;
  localparam logic [2:0] REQ_RSVD_B = 3'd7;
  localparam int POOL_SIZE   = 40;
  localparam int SEGMENTS    = 14;
  localparam int SEG_ITEMS   = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 60;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;

  // Shared between the request process and the result-side process.
  bit idle_on;
  bit hold_req;

  // Pool of well-formed names so that lookups and deletes hit.
  logic [95:0] name_pool [POOL_SIZE];
  int          pool_len  [POOL_SIZE];

  fdt_in_if  in_chan ();
  fdt_out_if out_chan ();

  file_directory_table_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fdt_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fails),
    .pending_count (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run when nothing transfers for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("file_directory_table_core: mismatch");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, and a long hold-off when asked.
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offer one request, wait for its transfer, then maybe leave a gap.
  task automatic offer_request(input logic [2:0] rq, input logic [95:0] nm,
                               input logic [5:0] start);
    in_chan.valid       <= 1'b1;
    in_chan.req_type    <= rq;
    in_chan.name_low    <= nm[63:0];
    in_chan.name_high   <= nm[95:64];
    in_chan.start_index <= start;
    do @(posedge clk); while (!in_chan.ready);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Pick a name: mostly pool names, half of them with random bytes after the NUL,
  // sometimes an empty name or a fully random one.
  function automatic logic [95:0] pick_name();
    logic [95:0] nm;
    int          sel;
    int          idx;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      nm = {$urandom(), $urandom(), $urandom()};
      nm[7:0] = 8'h00;
    end else if (sel < 20) begin
      nm = {$urandom(), $urandom(), $urandom()};
    end else begin
      idx = $urandom_range(0, POOL_SIZE - 1);
      nm  = name_pool[idx];
      if (sel < 60) begin
        for (int k = pool_len[idx] + 1; k < NAME_BYTES; k++) nm[8*k +: 8] = 8'($urandom());
      end
    end
    return nm;
  endfunction

  // Reset, directed requests, then random segments.
  initial begin : stimulus
    logic [95:0] nm;
    logic [2:0]  rq;
    logic [5:0]  start;
    int          mix;
    int          roll;
    bit          table_up;

    idle_on  = 1'b1;
    hold_req = 1'b0;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.req_type    <= REQ_FORMAT;
    in_chan.name_low    <= '0;
    in_chan.name_high   <= '0;
    in_chan.start_index <= '0;

    // Pool names differ in byte 1; byte 0 and the length are random.
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_len[i] = $urandom_range(2, NAME_BYTES);
      name_pool[i] = '0;
      name_pool[i][7:0]  = 8'($urandom_range(1, 255));
      name_pool[i][15:8] = 8'(i + 1);
      for (int k = 2; k < pool_len[i]; k++) name_pool[i][8*k +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unmounted table: every table operation fails; unmount still succeeds.
    offer_request(REQ_LOOKUP, {96{1'b1}}, 6'd0);
    offer_request(REQ_CREATE, {96{1'b1}}, 6'd0);
    offer_request(REQ_DELETE, {96{1'b1}}, 6'd0);
    offer_request(REQ_NEXT, '0, 6'd0);
    offer_request(REQ_UNMOUNT, '0, 6'd63);
    offer_request(REQ_RSVD_A, {96{1'b1}}, 6'd63);
    offer_request(REQ_RSVD_B, '0, 6'd0);
    // Fresh table: empty scans, empty names, duplicates.
    offer_request(REQ_FORMAT, '0, 6'd0);
    offer_request(REQ_NEXT, '0, 6'd0);
    offer_request(REQ_LOOKUP, '0, 6'd0);
    offer_request(REQ_CREATE, {32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00}, 6'd0);
    offer_request(REQ_CREATE, {96{1'b1}}, 6'd0);
    offer_request(REQ_CREATE, {96{1'b1}}, 6'd0);
    // Short name: bytes after the NUL do not take part in the match.
    offer_request(REQ_CREATE, {32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_0078}, 6'd0);
    offer_request(REQ_LOOKUP, {32'h0000_0000, 64'hC3C3_C3C3_C3C3_0078}, 6'd0);
    // Full-length name: all twelve bytes count.
    offer_request(REQ_CREATE, {32'h0102_0304, 64'h1112_1314_1516_1718}, 6'd0);
    offer_request(REQ_LOOKUP, {32'h8102_0304, 64'h1112_1314_1516_1718}, 6'd0);
    offer_request(REQ_NEXT, '0, 6'd2);
    offer_request(REQ_NEXT, '0, 6'd31);
    offer_request(REQ_NEXT, '0, 6'd32);
    offer_request(REQ_NEXT, '0, 6'd63);
    // Deleting an empty name succeeds; a second delete of a name fails.
    offer_request(REQ_DELETE, '0, 6'd0);
    offer_request(REQ_DELETE, {32'h0000_0000, 64'hC3C3_C3C3_C3C3_0078}, 6'd0);
    offer_request(REQ_DELETE, {32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_0078}, 6'd0);
    offer_request(REQ_FORMAT, '0, 6'd0);
    offer_request(REQ_UNMOUNT, '0, 6'd0);
    table_up = 1'b0;

    // Random segments, each with its own operation mix.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      mix     = $urandom_range(0, 2);
      idle_on = (seg < SEGMENTS - 2) && ($urandom_range(0, 3) != 0);
      if (seg == 4 || seg == 9) hold_req = 1'b1;
      if (seg == 6 || seg == 11) begin
        // Step past the last transfer so that its answer is already counted.
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      for (int n = 0; n < SEG_ITEMS; n++) begin
        nm    = pick_name();
        start = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, ENTRIES - 1));
        roll  = $urandom_range(0, 99);
        if (!table_up && roll < 25) begin
          rq = REQ_FORMAT;
        end else if (table_up && roll < 1) begin
          rq = REQ_FORMAT;
        end else if (table_up && roll < 2) begin
          rq = REQ_UNMOUNT;
        end else if (roll >= 98) begin
          rq = roll[0] ? REQ_RSVD_A : REQ_RSVD_B;
        end else begin
          roll = $urandom_range(0, 99);
          case (mix)
            0:       rq = (roll < 60) ? REQ_CREATE : (roll < 70) ? REQ_DELETE :
                          (roll < 85) ? REQ_LOOKUP : REQ_NEXT;
            1:       rq = (roll < 30) ? REQ_CREATE : (roll < 55) ? REQ_DELETE :
                          (roll < 80) ? REQ_LOOKUP : REQ_NEXT;
            default: rq = (roll < 15) ? REQ_CREATE : (roll < 55) ? REQ_DELETE :
                          (roll < 80) ? REQ_LOOKUP : REQ_NEXT;
          endcase
        end
        if (rq == REQ_FORMAT) table_up = 1'b1;
        if (rq == REQ_UNMOUNT) table_up = 1'b0;
        offer_request(rq, nm, start);
      end
    end

    // Drain, let the core settle, then give the verdict.
    in_chan.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("file_directory_table_core: match");
    end else begin
      $display("file_directory_table_core: mismatch");
    end
    $finish;
  end

endmodule
